// ----- src/hsfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfe_pkg
// Shared widths, types and constants for the harmonic spring force block.
// ----------------------------------------------------------------------------
package hsfe_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam int COORD_W  = 32;
  localparam int K_W      = 32;
  localparam int R_W      = 31;
  localparam int IDX_W    = 16;
  localparam int FORCE_W  = 48;
  localparam int ENERGY_W = 63;

  localparam int DM_W  = COORD_W + 1;   // magnitude of a coordinate difference
  localparam int LEN_W = 34;            // floor(sqrt(d2))
  localparam int D2_W  = 66;            // dx^2+dy^2+dz^2
  localparam int MA_W  = 68;            // multiplicand
  localparam int MB_W  = 34;            // multiplier, consumed one bit a cycle
  localparam int MP_W  = MA_W + MB_W;   // product

  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 224;

  typedef enum logic [3:0] {
    MS_DX, MS_DY, MS_DZ, MS_KD, MS_DD, MS_EK, MS_NX, MS_NY, MS_NZ
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     sqrt_start;
    logic     div_start;
    logic [1:0] comp;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- src/hsfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfe_ctrl
// Sequencer: runs multiplies, square root and divides for one item.
// ----------------------------------------------------------------------------
module hsfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  hsfe_pkg::sts_t    sts_i,
  output hsfe_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_OUT} state_e;

  state_e             state_q;
  hsfe_pkg::mul_sel_e sel_q;
  logic [1:0]         comp_q;
  logic               mul_start_q, sqrt_start_q, div_start_q;

  assign s_tready_o        = (state_q == S_IDLE);
  assign cmd_o.load        = s_tvalid_i && (state_q == S_IDLE);
  assign cmd_o.mul_start   = mul_start_q;
  assign cmd_o.mul_sel     = sel_q;
  assign cmd_o.sqrt_start  = sqrt_start_q;
  assign cmd_o.div_start   = div_start_q;
  assign cmd_o.comp        = comp_q;
  assign cmd_o.finish      = (state_q == S_OUT) && !sts_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sel_q        <= hsfe_pkg::MS_DX;
      comp_q       <= 2'd0;
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
    end else begin
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            state_q     <= S_MUL;
            sel_q       <= hsfe_pkg::MS_DX;
            mul_start_q <= 1'b1;
          end
        end
        S_MUL: begin
          if (sts_i.mul_done) begin
            case (sel_q)
              hsfe_pkg::MS_DX: begin
                sel_q <= hsfe_pkg::MS_DY; mul_start_q <= 1'b1;
              end
              hsfe_pkg::MS_DY: begin
                sel_q <= hsfe_pkg::MS_DZ; mul_start_q <= 1'b1;
              end
              hsfe_pkg::MS_DZ: begin
                state_q <= S_SQRT; sqrt_start_q <= 1'b1;
              end
              hsfe_pkg::MS_KD: begin
                sel_q <= hsfe_pkg::MS_DD; mul_start_q <= 1'b1;
              end
              hsfe_pkg::MS_DD: begin
                sel_q <= hsfe_pkg::MS_EK; mul_start_q <= 1'b1;
              end
              hsfe_pkg::MS_EK: begin
                sel_q <= hsfe_pkg::MS_NX; comp_q <= 2'd0; mul_start_q <= 1'b1;
              end
              default: begin
                state_q <= S_DIV; div_start_q <= 1'b1;
              end
            endcase
          end
        end
        S_SQRT: begin
          if (sts_i.sqrt_done) begin
            state_q     <= S_MUL;
            sel_q       <= hsfe_pkg::MS_KD;
            mul_start_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            if (comp_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              state_q     <= S_MUL;
              sel_q       <= (comp_q == 2'd0) ? hsfe_pkg::MS_NY : hsfe_pkg::MS_NZ;
              comp_q      <= comp_q + 2'd1;
              mul_start_q <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!sts_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/hsfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfe_dp
// Datapath: shift-add multiplier, digit sqrt, restoring divider, energy sum.
// ----------------------------------------------------------------------------
module hsfe_dp #(
  parameter int FRAC_BITS  = hsfe_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = hsfe_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hsfe_pkg::cmd_t                    cmd_i,
  output hsfe_pkg::sts_t                    sts_o,
  input  logic [2:0][hsfe_pkg::COORD_W-1:0] anchor_i,
  input  logic [2:0][hsfe_pkg::COORD_W-1:0] bead_i,
  input  logic [hsfe_pkg::K_W-1:0]          stiffness_i,
  input  logic [hsfe_pkg::R_W-1:0]          rest_length_i,
  input  logic [hsfe_pkg::IDX_W-1:0]        bead_index_i,
  input  logic                              last_i,
  input  logic                              m_tready_i,
  output logic                              m_tvalid_o,
  output logic [2:0][hsfe_pkg::FORCE_W-1:0] force_o,
  output logic [hsfe_pkg::IDX_W-1:0]        target_index_o,
  output logic [hsfe_pkg::ENERGY_W-1:0]     energy_total_o,
  output logic                              zero_distance_o,
  output logic                              batch_end_o
);

  localparam int DM_W  = hsfe_pkg::DM_W;
  localparam int LEN_W = hsfe_pkg::LEN_W;
  localparam int D2_W  = hsfe_pkg::D2_W;
  localparam int MA_W  = hsfe_pkg::MA_W;
  localparam int MB_W  = hsfe_pkg::MB_W;
  localparam int MP_W  = hsfe_pkg::MP_W;
  localparam int FW    = hsfe_pkg::FORCE_W;
  localparam int EW    = hsfe_pkg::ENERGY_W;
  localparam int SR_W  = LEN_W + 3;
  localparam int RAD_W = 2 * LEN_W;
  localparam int DV_W  = LEN_W + FRAC_BITS;
  localparam int E_SH  = 2 * FRAC_BITS + 1;
  localparam int MC_W  = $clog2(MB_W);
  localparam int DC_W  = $clog2(MP_W);
  localparam int KEEP  = (INDEX_BITS < hsfe_pkg::IDX_W) ? INDEX_BITS : hsfe_pkg::IDX_W;
  localparam logic [hsfe_pkg::IDX_W-1:0] IDX_MASK =
    hsfe_pkg::IDX_W'((64'd1 << KEEP) - 64'd1);
  localparam logic [FW-1:0] POS_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] NEG_MAG = {1'b1, {(FW-1){1'b0}}};
  localparam logic [EW-1:0] E_MAX   = {EW{1'b1}};

  // captured item
  logic [2:0][hsfe_pkg::COORD_W-1:0] a_q, b_q;
  logic [hsfe_pkg::K_W-1:0]   k_q;
  logic [hsfe_pkg::R_W-1:0]   r_q;
  logic [hsfe_pkg::IDX_W-1:0] idx_q;
  logic                       last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= anchor_i; b_q <= bead_i; k_q <= stiffness_i;
      r_q <= rest_length_i; idx_q <= bead_index_i; last_q <= last_i;
    end
  end

  // coordinate differences
  logic [2:0][DM_W-1:0] ds, dm;
  logic [2:0]           neg_d, nz_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ds[i]    = {a_q[i][hsfe_pkg::COORD_W-1], a_q[i]} - {b_q[i][hsfe_pkg::COORD_W-1], b_q[i]};
      neg_d[i] = ds[i][DM_W-1];
      nz_d[i]  = |ds[i];
      dm[i]    = neg_d[i] ? (~ds[i] + DM_W'(1)) : ds[i];
    end
  end

  logic [LEN_W-1:0] len;
  logic [LEN_W+1:0] diff;
  logic             neg_diff;
  logic [LEN_W-1:0] dmg;
  assign diff     = {2'b00, len} - (LEN_W+2)'(r_q);
  assign neg_diff = diff[LEN_W+1];
  assign dmg      = neg_diff ? LEN_W'(~diff + (LEN_W+2)'(1)) : diff[LEN_W-1:0];

  // ---- shift-add multiplier, one multiplier bit a cycle, MSB first
  logic [D2_W-1:0] d2_q, kd_q;
  logic [MA_W-1:0] dd_q;
  logic [MP_W-1:0] ek_q, num_q;
  logic [MA_W-1:0] op_a, ma_q;
  logic [MB_W-1:0] op_b, mb_q;
  logic [MP_W-1:0] mp_q;
  logic [MC_W-1:0] mcnt_q;
  logic            mbusy_q, mdone_q;

  always_comb begin
    case (cmd_i.mul_sel)
      hsfe_pkg::MS_DX: begin op_a = MA_W'(dm[0]); op_b = MB_W'(dm[0]); end
      hsfe_pkg::MS_DY: begin op_a = MA_W'(dm[1]); op_b = MB_W'(dm[1]); end
      hsfe_pkg::MS_DZ: begin op_a = MA_W'(dm[2]); op_b = MB_W'(dm[2]); end
      hsfe_pkg::MS_KD: begin op_a = MA_W'(k_q);   op_b = MB_W'(dmg);   end
      hsfe_pkg::MS_DD: begin op_a = MA_W'(dmg);   op_b = MB_W'(dmg);   end
      hsfe_pkg::MS_EK: begin op_a = dd_q;         op_b = MB_W'(k_q);   end
      hsfe_pkg::MS_NX: begin op_a = MA_W'(kd_q);  op_b = MB_W'(dm[0]); end
      hsfe_pkg::MS_NY: begin op_a = MA_W'(kd_q);  op_b = MB_W'(dm[1]); end
      hsfe_pkg::MS_NZ: begin op_a = MA_W'(kd_q);  op_b = MB_W'(dm[2]); end
      default:         begin op_a = '0;           op_b = '0;           end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0; mdone_q <= 1'b0; mcnt_q <= '0;
      ma_q <= '0; mb_q <= '0; mp_q <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (cmd_i.mul_start) begin
        ma_q <= op_a; mb_q <= op_b; mp_q <= '0; mcnt_q <= '0; mbusy_q <= 1'b1;
      end else if (mbusy_q) begin
        mp_q   <= {mp_q[MP_W-2:0], 1'b0} + (mb_q[MB_W-1] ? MP_W'(ma_q) : '0);
        mb_q   <= {mb_q[MB_W-2:0], 1'b0};
        mcnt_q <= mcnt_q + MC_W'(1);
        if (mcnt_q == MC_W'(MB_W - 1)) begin
          mbusy_q <= 1'b0; mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mdone_q) begin
      case (cmd_i.mul_sel)
        hsfe_pkg::MS_DX: d2_q <= mp_q[D2_W-1:0];
        hsfe_pkg::MS_DY,
        hsfe_pkg::MS_DZ: d2_q <= d2_q + mp_q[D2_W-1:0];
        hsfe_pkg::MS_KD: kd_q <= mp_q[D2_W-1:0];
        hsfe_pkg::MS_DD: dd_q <= mp_q[MA_W-1:0];
        hsfe_pkg::MS_EK: ek_q <= mp_q;
        default:         num_q <= mp_q;
      endcase
    end
  end

  // ---- digit-by-digit square root, two radicand bits a cycle
  logic [RAD_W-1:0] rad_q;
  logic [SR_W-1:0]  srem_q, srem_sh, strial;
  logic [LEN_W-1:0] root_q;
  logic [MC_W-1:0]  scnt_q;
  logic             sbusy_q, sdone_q;

  assign len     = root_q;
  assign srem_sh = {srem_q[SR_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign strial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0; sdone_q <= 1'b0; scnt_q <= '0;
      rad_q <= '0; srem_q <= '0; root_q <= '0;
    end else begin
      sdone_q <= 1'b0;
      if (cmd_i.sqrt_start) begin
        rad_q <= RAD_W'(d2_q); srem_q <= '0; root_q <= '0;
        scnt_q <= '0; sbusy_q <= 1'b1;
      end else if (sbusy_q) begin
        rad_q <= {rad_q[RAD_W-3:0], 2'b00};
        if (srem_sh >= strial) begin
          srem_q <= srem_sh - strial; root_q <= {root_q[LEN_W-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;          root_q <= {root_q[LEN_W-2:0], 1'b0};
        end
        scnt_q <= scnt_q + MC_W'(1);
        if (scnt_q == MC_W'(LEN_W - 1)) begin
          sbusy_q <= 1'b0; sdone_q <= 1'b1;
        end
      end
    end
  end

  // ---- restoring divider by L * 2^FRAC_BITS, one quotient bit a cycle
  logic [DV_W-1:0] dv;
  logic [DV_W:0]   dr_q, dr_sh;
  logic [MP_W-1:0] dn_q;
  logic [DC_W-1:0] dcnt_q;
  logic            dbusy_q, ddone_q, qbit;

  assign dv    = DV_W'(len) << FRAC_BITS;
  assign dr_sh = {dr_q[DV_W-1:0], dn_q[MP_W-1]};
  assign qbit  = (dr_sh >= {1'b0, dv});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0; ddone_q <= 1'b0; dcnt_q <= '0; dr_q <= '0; dn_q <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_start) begin
        dn_q <= num_q; dr_q <= '0; dcnt_q <= '0; dbusy_q <= 1'b1;
      end else if (dbusy_q) begin
        dr_q   <= qbit ? (dr_sh - {1'b0, dv}) : dr_sh;
        dn_q   <= {dn_q[MP_W-2:0], qbit};
        dcnt_q <= dcnt_q + DC_W'(1);
        if (dcnt_q == DC_W'(MP_W - 1)) begin
          dbusy_q <= 1'b0; ddone_q <= 1'b1;
        end
      end
    end
  end

  // signed, saturated force component from the quotient
  logic          fneg, fgate;
  logic [FW-1:0] flim, fmag, fval;
  logic [2:0][FW-1:0] f_q;
  always_comb begin
    fneg  = neg_diff ^ neg_d[cmd_i.comp];
    flim  = fneg ? NEG_MAG : POS_MAX;
    fmag  = ((|dn_q[MP_W-1:FW]) || (dn_q[FW-1:0] > flim)) ? flim : dn_q[FW-1:0];
    fval  = fneg ? (~fmag + FW'(1)) : fmag;
    fgate = (|len) && (|dmg) && nz_d[cmd_i.comp];
  end

  always_ff @(posedge clk_i) begin
    if (ddone_q) f_q[cmd_i.comp] <= fgate ? fval : '0;
  end

  // energy term and running sum
  logic [MP_W-1:0] esh;
  logic [EW-1:0]   eterm, esum_q, enew;
  logic [EW:0]     eadd;
  logic            ovalid_q;
  assign esh   = ek_q >> E_SH;
  assign eterm = (|esh[MP_W-1:EW]) ? E_MAX : esh[EW-1:0];
  assign eadd  = {1'b0, esum_q} + {1'b0, eterm};
  assign enew  = eadd[EW] ? E_MAX : eadd[EW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        esum_q   <= last_q ? '0 : enew;
        ovalid_q <= 1'b1;
      end else if (ovalid_q && m_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      force_o         <= f_q;
      target_index_o  <= idx_q & IDX_MASK;
      energy_total_o  <= enew;
      zero_distance_o <= ~(|len);
      batch_end_o     <= last_q;
    end
  end

  assign m_tvalid_o      = ovalid_q;
  assign sts_o.mul_done  = mdone_q;
  assign sts_o.sqrt_done = sdone_q;
  assign sts_o.div_done  = ddone_q;
  assign sts_o.out_busy  = ovalid_q && !m_tready_i;

endmodule

// ----- src/harmonic_spring_force_energy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_spring_force_energy
// Harmonic spring force on a bead plus running energy sum, Q16.16 in.
// ----------------------------------------------------------------------------
// One spring per input item, one result per item. Between acceptance and
// result an item runs nine products on a shared shift-add multiplier, a
// 34-step square root, three 102-step restoring divides and a load of the
// output register. Input is taken again as soon as the result is in the
// output register, so the next spring runs while that result waits; if it
// is still waiting when the next result is ready, the sequencer holds until
// it is taken. Energy sum is cleared after the item with tlast set.
// ----------------------------------------------------------------------------
module harmonic_spring_force_energy #(
  parameter int FRAC_BITS  = hsfe_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = hsfe_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // anchor_x, anchor_y, anchor_z, bead_x, bead_y, bead_z, stiffness,
  // rest_length, bead_index, one pad bit
  input  logic [hsfe_pkg::IN_DATA_W-1:0]     s_tdata_i,
  input  logic                               s_tlast_i,   // last
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // force_x, force_y, force_z, target_index, energy_total, one pad bit
  output logic [hsfe_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  output logic                               m_tuser_o,   // zero_distance
  output logic                               m_tlast_o,   // batch_end
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i
);

  hsfe_pkg::cmd_t cmd;
  hsfe_pkg::sts_t sts;

  logic [2:0][hsfe_pkg::COORD_W-1:0] anchor, bead;
  logic [2:0][hsfe_pkg::FORCE_W-1:0] force_v;
  logic [hsfe_pkg::IDX_W-1:0]        target_index;
  logic [hsfe_pkg::ENERGY_W-1:0]     energy_total;

  // unpack the input item
  assign anchor[0] = s_tdata_i[31:0];
  assign anchor[1] = s_tdata_i[63:32];
  assign anchor[2] = s_tdata_i[95:64];
  assign bead[0]   = s_tdata_i[127:96];
  assign bead[1]   = s_tdata_i[159:128];
  assign bead[2]   = s_tdata_i[191:160];

  hsfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsfe_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .anchor_i        (anchor),
    .bead_i          (bead),
    .stiffness_i     (s_tdata_i[223:192]),
    .rest_length_i   (s_tdata_i[254:224]),
    .bead_index_i    (s_tdata_i[270:255]),
    .last_i          (s_tlast_i),
    .m_tready_i      (m_tready_i),
    .m_tvalid_o      (m_tvalid_o),
    .force_o         (force_v),
    .target_index_o  (target_index),
    .energy_total_o  (energy_total),
    .zero_distance_o (m_tuser_o),
    .batch_end_o     (m_tlast_o)
  );

  // pack the result item
  assign m_tdata_o = {1'b0, energy_total, target_index, force_v[2], force_v[1], force_v[0]};

endmodule

// ----- src/hsfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfe_checker
// Port-level checks for the harmonic spring block, bound to the top level.
// ----------------------------------------------------------------------------
module hsfe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [hsfe_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input logic                            s_tlast_i,
  input logic                            s_tvalid_i,
  input logic                            s_tready_o,
  input logic [hsfe_pkg::OUT_DATA_W-1:0] m_tdata_o,
  input logic                            m_tuser_o,
  input logic                            m_tlast_o,
  input logic                            m_tvalid_o,
  input logic                            m_tready_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o)
      && $stable(m_tuser_o) && $stable(m_tlast_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken while busy");

  // a result never appears in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !$rose(m_tvalid_o))
    else $error("result too early");

  // coinciding points give zero force
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> (m_tdata_o[143:0] == 144'd0))
    else $error("nonzero force at zero distance");

endmodule

bind harmonic_spring_force_energy hsfe_checker u_hsfe_checker (.*);

// ----- tb/harmonic_spring_force_energy_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_spring_force_energy_tb
// Self-checking bench for the harmonic spring force and energy block.
// ----------------------------------------------------------------------------
// A table of directed springs comes first. A few rows carry an expected
// result typed in by hand: coinciding points, a unit spring, and a saturated
// spring. Random batches of springs follow. Every result is compared field by
// field with the oldest entry of a queue, filled with the typed result if any,
// else by an in-bench force/energy predictor. The sender runs in bursts; the
// receiver stalls on its own patterns. A watchdog ends the run if nothing moves.
// ----------------------------------------------------------------------------
module harmonic_spring_force_energy_tb;

  localparam int HALF_PERIOD = 6;
  localparam int TAIL_CYCLES = 800;      // outlasts the run of one spring
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 850;
  localparam logic [62:0] ENERGY_MAX = {63{1'b1}};

  typedef struct {
    logic signed [hsfe_pkg::COORD_W-1:0] ax, ay, az, bx, by, bz;
    logic [hsfe_pkg::K_W-1:0]            k;
    logic [hsfe_pkg::R_W-1:0]            rest;
    logic [hsfe_pkg::IDX_W-1:0]          idx;
    logic                                last;
  } spring_t;

  typedef struct {
    logic [hsfe_pkg::FORCE_W-1:0]  fx, fy, fz;
    logic [hsfe_pkg::IDX_W-1:0]    idx;
    logic [hsfe_pkg::ENERGY_W-1:0] energy;
    logic                          zero_dist;
    logic                          batch_end;
  } spring_res_t;

  // one directed row; typed_ok marks a hand-typed expected result
  typedef struct {
    spring_t     sp;
    logic        typed_ok;
    spring_res_t typed;
  } stim_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic [hsfe_pkg::IN_DATA_W-1:0]  s_tdata_i;
  logic                            s_tlast_i;
  logic                            s_tvalid_i;
  logic                            s_tready_o;
  logic [hsfe_pkg::OUT_DATA_W-1:0] m_tdata_o;
  logic                            m_tuser_o;
  logic                            m_tlast_o;
  logic                            m_tvalid_o;
  logic                            m_tready_i;

  spring_res_t    force_q[$];   // results waiting to come out of the block
  logic [63:0]    energy_acc;   // predictor copy of the running energy sum
  int             err_cnt;
  int             idle_cycles;
  stim_row_t      stim_tab[$];

  harmonic_spring_force_energy dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Force and energy of one spring; advances energy_acc like the block does.
  function automatic spring_res_t spring_force(spring_t s);
    logic signed [33:0] dv[3];
    logic [127:0]       mag[3];
    logic [127:0]       d2, len, cand, dm, num, quo, lim, eterm;
    logic signed [63:0] diff;
    logic               neg_diff, neg;
    logic [47:0]        f[3];
    spring_res_t        r;
    dv[0] = 34'(s.ax) - 34'(s.bx);
    dv[1] = 34'(s.ay) - 34'(s.by);
    dv[2] = 34'(s.az) - 34'(s.bz);
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = dv[i][33] ? 128'(-dv[i]) : 128'(dv[i]);
      d2 += mag[i] * mag[i];
    end
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= d2) len = cand;
    end
    diff = $signed(len[63:0]) - $signed({33'b0, s.rest});
    neg_diff = diff < 0;
    dm = neg_diff ? 128'(-diff) : 128'(diff);
    for (int i = 0; i < 3; i++) begin
      f[i] = '0;
      if (len != 0 && dm != 0 && mag[i] != 0) begin
        num = 128'(s.k) * dm * mag[i];
        quo = num / (len << hsfe_pkg::FRAC_BITS_DEF);
        neg = neg_diff != dv[i][33];
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        if (quo > lim) quo = lim;
        f[i] = neg ? -quo[47:0] : quo[47:0];
      end
    end
    // 0.5*k*diff^2 with the extra halving folded into the shift
    eterm = (dm * dm * 128'(s.k)) >> (2 * hsfe_pkg::FRAC_BITS_DEF + 1);
    if (eterm > 128'(ENERGY_MAX)) eterm = 128'(ENERGY_MAX);
    energy_acc += eterm[63:0];
    if (energy_acc > 64'(ENERGY_MAX)) energy_acc = 64'(ENERGY_MAX);
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    r.idx = s.idx;
    r.energy = energy_acc[62:0];
    r.zero_dist = (len == 0);
    r.batch_end = s.last;
    if (s.last) energy_acc = '0;
    return r;
  endfunction

  // Coordinate: half moderate values so springs stay in range, half full range.
  function automatic logic [31:0] rand_coord(int spread);
    case (spread)
      0:       return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
      1:       return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
      default: return $urandom;
    endcase
  endfunction

  function automatic spring_t rand_spring(logic last);
    spring_t s;
    int      spread;
    spread = $urandom_range(0, 3);
    s.ax = rand_coord(spread);
    s.ay = rand_coord(spread);
    s.az = rand_coord(spread);
    // some beads share a coordinate or coincide with the anchor
    s.bx = ($urandom_range(0, 9) == 0) ? s.ax : rand_coord(spread);
    s.by = ($urandom_range(0, 9) == 0) ? s.ay : rand_coord(spread);
    s.bz = ($urandom_range(0, 9) == 0) ? s.az : rand_coord(spread);
    if ($urandom_range(0, 24) == 0) begin
      s.bx = s.ax;
      s.by = s.ay;
      s.bz = s.az;
    end
    case ($urandom_range(0, 3))
      0:       s.k = $urandom;
      1:       s.k = $urandom_range(0, 2 ** 20);
      2:       s.k = 32'h0001_0000;
      default: s.k = $urandom_range(0, 2 ** 12);
    endcase
    case ($urandom_range(0, 2))
      0:       s.rest = 31'($urandom);
      1:       s.rest = 31'($urandom_range(0, 2 ** 20));
      default: s.rest = '0;
    endcase
    s.idx = 16'($urandom);
    s.last = last;
    return s;
  endfunction

  function automatic spring_t mk_spring(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                        logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                        logic [31:0] k, logic [30:0] rest,
                                        logic [15:0] idx, logic last);
    spring_t s;
    s.ax = ax; s.ay = ay; s.az = az;
    s.bx = bx; s.by = by; s.bz = bz;
    s.k = k; s.rest = rest; s.idx = idx; s.last = last;
    return s;
  endfunction

  function automatic void add_row(spring_t s, logic typed_ok, logic [47:0] fx,
                                  logic [62:0] energy, logic zd);
    stim_row_t row;
    row.sp = s;
    row.typed_ok = typed_ok;
    row.typed.fx = fx;
    row.typed.fy = '0;
    row.typed.fz = '0;
    row.typed.idx = s.idx;
    row.typed.energy = energy;
    row.typed.zero_dist = zd;
    row.typed.batch_end = s.last;
    stim_tab.push_back(row);
  endfunction

  // Drive one spring and hold it until the block takes it.
  task automatic send_spring(spring_t s, logic typed_ok, spring_res_t typed);
    spring_res_t pred;
    s_tdata_i  <= {1'b0, s.idx, s.rest, s.k, s.bz, s.by, s.bx, s.az, s.ay, s.ax};
    s_tlast_i  <= s.last;
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    pred = spring_force(s);
    force_q.push_back(typed_ok ? typed : pred);
  endtask

  // Sender: bursts of random length with random gaps in between.
  int burst_left;
  task automatic pace_sender();
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  initial begin
    spring_res_t none;
    int          batch_len;
    none = '{default: '0};
    rst_ni     = 1'b0;
    s_tdata_i  = '0;
    s_tlast_i  = 1'b0;
    s_tvalid_i = 1'b0;
    energy_acc = '0;
    err_cnt    = 0;
    burst_left = 0;

    // coinciding points at origin, nothing stored yet
    add_row(mk_spring(0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 1'b1), 1'b1, '0, '0, 1'b1);
    // unit spring along x, zero rest length: force 1.0, energy 0.5
    add_row(mk_spring(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 16'hFFFF, 1'b1),
            1'b1, 48'h0000_0001_0000, 63'h8000, 1'b0);
    // widest span with largest k: force saturates, energy lands just below max
    add_row(mk_spring(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 0,
                      16'h5A5A, 1'b1), 1'b1, 48'h7FFF_FFFF_FFFF,
            63'h7FFF_FFFE_8000_0001, 1'b0);
    // coinciding points still pay 0.5*k*r^2
    add_row(mk_spring(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000, 31'h0002_0000,
                      16'h0001, 1'b0), 1'b0, '0, '0, 1'b0);
    // sum stuck at max within a batch, then cleared
    add_row(mk_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 16'h8000, 1'b0),
            1'b0, '0, '0, 1'b0);
    add_row(mk_spring(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 16'h0002, 1'b1),
            1'b0, '0, '0, 1'b0);
    // compressed spring (L < r), whose force pushes the bead away, then a stretched one: all sign combinations
    add_row(mk_spring(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 0,
                      32'h0002_0000, 31'h0005_0000, 16'h0003, 1'b0), 1'b0, '0, '0, 1'b0);
    add_row(mk_spring(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 0, 0, 0,
                      32'h0002_0000, 31'h0000_1000, 16'h0004, 1'b0), 1'b0, '0, '0, 1'b0);
    // at rest length exactly: no force
    add_row(mk_spring(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h0010_0000,
                      31'h0005_0000, 16'h0005, 1'b0), 1'b0, '0, '0, 1'b0);
    // largest rest length, tiny spring: big negative diff
    add_row(mk_spring(1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'h0006, 1'b0),
            1'b0, '0, '0, 1'b0);
    // full-span diagonal with max rest length
    add_row(mk_spring(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 31'h7FFF_FFFF,
                      16'h00FF, 1'b1), 1'b0, '0, '0, 1'b0);
    // single-LSB distances on the y and z axes
    add_row(mk_spring(0, 1, 0, 0, 0, 0, 32'h0001_0000, 0, 16'h0007, 1'b0), 1'b0, '0, '0, 1'b0);
    add_row(mk_spring(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h0001_0000, 1, 16'h0008, 1'b1),
            1'b0, '0, '0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[i]) begin
      pace_sender();
      send_spring(stim_tab[i].sp, stim_tab[i].typed_ok, stim_tab[i].typed);
    end

    // random batches; once the sender drains the block completely
    batch_len = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (batch_len == 0) batch_len = $urandom_range(1, 12);
      batch_len--;
      if (n == RAND_ITEMS / 2) begin
        s_tvalid_i <= 1'b0;
        while (force_q.size() != 0) @(posedge clk_i);
      end
      pace_sender();
      send_spring(rand_spring(batch_len == 0 || n == RAND_ITEMS - 1), 1'b0, none);
    end
    s_tvalid_i <= 1'b0;

    while (force_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("harmonic_spring_force_energy: match");
    end else begin
      $display("harmonic_spring_force_energy: mismatch");
    end
    $finish;
  end

  // Receiver: switches among always-ready, coin-flip, rotating pattern
  // and long stalls.
  logic [1:0]  rdy_mode;
  logic [7:0]  rdy_pat;
  int          rdy_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      rdy_mode   <= '0;
      rdy_pat    <= 8'b1011_0010;
      rdy_cnt    <= 0;
    end else begin
      rdy_cnt <= rdy_cnt + 1;
      if (rdy_cnt % 97 == 0) begin
        rdy_mode <= 2'($urandom);
        rdy_pat  <= 8'($urandom);
      end else begin
        rdy_pat <= {rdy_pat[6:0], rdy_pat[7]};
      end
      case (rdy_mode)
        2'd0:    m_tready_i <= 1'b1;
        2'd1:    m_tready_i <= 1'($urandom);
        2'd2:    m_tready_i <= rdy_pat[0];
        default: m_tready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    spring_res_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.fx        = m_tdata_o[47:0];
      got.fy        = m_tdata_o[95:48];
      got.fz        = m_tdata_o[143:96];
      got.idx       = m_tdata_o[159:144];
      got.energy    = m_tdata_o[222:160];
      got.zero_dist = m_tuser_o;
      got.batch_end = m_tlast_o;
      if (force_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
      end else begin
        want = force_q.pop_front();
        if (got.fx !== want.fx) begin
          err_cnt++;
          $display("%0t: force_x expected %h actual %h", $realtime, want.fx, got.fx);
        end
        if (got.fy !== want.fy) begin
          err_cnt++;
          $display("%0t: force_y expected %h actual %h", $realtime, want.fy, got.fy);
        end
        if (got.fz !== want.fz) begin
          err_cnt++;
          $display("%0t: force_z expected %h actual %h", $realtime, want.fz, got.fz);
        end
        if (got.idx !== want.idx) begin
          err_cnt++;
          $display("%0t: target_index expected %h actual %h", $realtime, want.idx, got.idx);
        end
        if (got.energy !== want.energy) begin
          err_cnt++;
          $display("%0t: energy_total expected %h actual %h", $realtime,
                   want.energy, got.energy);
        end
        if (got.zero_dist !== want.zero_dist) begin
          err_cnt++;
          $display("%0t: zero_distance expected %b actual %b", $realtime,
                   want.zero_dist, got.zero_dist);
        end
        if (got.batch_end !== want.batch_end) begin
          err_cnt++;
          $display("%0t: batch_end expected %b actual %b", $realtime,
                   want.batch_end, got.batch_end);
        end
      end
    end
  end

  // Watchdog: cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("harmonic_spring_force_energy: mismatch");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
